FILE: hdl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Types and constants of the preamble-synchronized bit deframer: frame layout,
// phase encoding, section tags and configuration register indexes.
// ----------------------------------------------------------------------------
package psd_pkg;

    // Frame layout
    localparam int PREAMBLE_BITS = 7 * 8 + 7;
    localparam int HEADER_BITS   = (6 + 6 + 2) * 8;
    localparam int ADDR_BITS     = 48;
    localparam int LEN_BITS      = 16;
    localparam int CRC_BITS      = 32;

    // Field widths
    localparam int THRESH_W  = 16;
    localparam int PAYLEN_W  = 14;
    localparam int INDEX_W   = 14;
    localparam int SECTION_W = 3;
    localparam int SYNC_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Section tags on the result channel
    typedef enum logic [SECTION_W-1:0] {
        SEC_DEST     = 3'd0,
        SEC_SOURCE   = 3'd1,
        SEC_LENGTH   = 3'd2,
        SEC_PAYLOAD  = 3'd3,
        SEC_CHECKSUM = 3'd4
    } section_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_POLARITY     = 2'd1,
        CFG_PAYLOAD_BITS = 2'd2
    } cfg_index_t;

    // Frame phase, one-hot
    typedef enum logic [3:0] {
        PH_HUNT     = 4'b0001,
        PH_HEADER   = 4'b0010,
        PH_PAYLOAD  = 4'b0100,
        PH_CHECKSUM = 4'b1000
    } phase_t;

    // Reset values of the configuration registers
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET    = 16'd100;
    localparam logic                POLARITY_RESET     = 1'b1;
    localparam logic [PAYLEN_W-1:0] PAYLOAD_BITS_RESET = 14'd64;

endpackage

FILE: hdl/preamble_sync_bit_deframer.sv
// ----------------------------------------------------------------------------
// preamble_sync_bit_deframer
// Slices one timing sample per bit, hunts for the preamble and start
// delimiter, then streams header, payload and checksum bits tagged by section.
// ----------------------------------------------------------------------------
// Each result passes through the input register and then the result register.
// Throughput: one sample per cycle while m_ready accepts results; the frame state updates once per sample.
// Preamble and delimiter samples give no result and drain without waiting for the result channel.
// Reset (aresetn low, synchronous): hunting, counters and shift registers clear,
// threshold 100, polarity 1, payload length 64.
module preamble_sync_bit_deframer #(
    parameter int SAMPLE_WIDTH     = 16,
    parameter int MAX_PAYLOAD_BITS = 12000
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [psd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // sample input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [SAMPLE_WIDTH-1:0]             s_sample,
    // bit results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_bit_res,
    output logic [psd_pkg::SECTION_W-1:0]       m_section,
    output logic [psd_pkg::INDEX_W-1:0]         m_bit_index,
    output logic                                m_last,
    output logic [psd_pkg::LEN_BITS-1:0]        m_length_field,
    output logic                                m_length_ok,
    output logic [psd_pkg::CRC_BITS-1:0]        m_checksum_field
);

    localparam int CMP_W = (SAMPLE_WIDTH > psd_pkg::THRESH_W) ? SAMPLE_WIDTH
                                                              : psd_pkg::THRESH_W;
    localparam int CNT_W = psd_pkg::INDEX_W + 1;

    // Configuration registers
    logic [psd_pkg::THRESH_W-1:0] threshold_reg;
    logic                         polarity_reg;
    logic [psd_pkg::PAYLEN_W-1:0] payload_bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= psd_pkg::THRESHOLD_RESET;
            polarity_reg     <= psd_pkg::POLARITY_RESET;
            payload_bits_reg <= psd_pkg::PAYLOAD_BITS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                psd_pkg::CFG_THRESHOLD: begin
                    threshold_reg <= cfg_wdata[psd_pkg::THRESH_W-1:0];
                end
                psd_pkg::CFG_POLARITY: begin
                    polarity_reg <= cfg_wdata[0];
                end
                psd_pkg::CFG_PAYLOAD_BITS: begin
                    payload_bits_reg <= cfg_wdata[psd_pkg::PAYLEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register
    logic                    in_valid_reg;
    logic [SAMPLE_WIDTH-1:0] in_sample_reg;

    // Frame state
    psd_pkg::phase_t              phase_reg, phase_next;
    logic [psd_pkg::SYNC_W-1:0]   sync_count_reg, sync_count_next;
    logic [psd_pkg::INDEX_W-1:0]  bit_count_reg, bit_count_next;
    logic [psd_pkg::LEN_BITS-1:0] length_shift_reg, length_shift_next;
    logic [psd_pkg::CRC_BITS-1:0] checksum_shift_reg, checksum_shift_next;

    // Result register
    logic                          out_valid_reg;
    logic                          out_bit_reg;
    logic [psd_pkg::SECTION_W-1:0] out_section_reg;
    logic [psd_pkg::INDEX_W-1:0]   out_index_reg;
    logic                          out_last_reg;
    logic [psd_pkg::LEN_BITS-1:0]  out_length_reg;
    logic                          out_length_ok_reg;
    logic [psd_pkg::CRC_BITS-1:0]  out_checksum_reg;

    // Per-sample combinational results
    logic                          bit_val;
    logic                          has_result;
    logic                          advance;
    logic                          out_load;
    logic [psd_pkg::PAYLEN_W-1:0]  payload_len;
    logic [CNT_W-1:0]              count_inc;
    psd_pkg::section_t             sec;
    logic [psd_pkg::INDEX_W-1:0]   idx;
    logic                          last_bit;

    // Slice the sample against the threshold
    always_comb begin
        logic above;
        above   = CMP_W'(in_sample_reg) > CMP_W'(threshold_reg);
        bit_val = polarity_reg ? above : !above;
    end

    // Saturate the payload length
    assign payload_len = (payload_bits_reg > psd_pkg::PAYLEN_W'(MAX_PAYLOAD_BITS))
                       ? psd_pkg::PAYLEN_W'(MAX_PAYLOAD_BITS) : payload_bits_reg;

    assign count_inc  = CNT_W'(bit_count_reg) + CNT_W'(1);
    assign has_result = (phase_reg != psd_pkg::PH_HUNT);

    // Advance the input register when the sample gives no result or the result slot is free or draining
    assign advance  = in_valid_reg && (!has_result || !out_valid_reg || m_ready);
    assign out_load = advance && has_result;
    assign s_ready  = !in_valid_reg || advance;

    // Next frame state and result fields
    always_comb begin
        phase_next          = phase_reg;
        sync_count_next     = sync_count_reg;
        bit_count_next      = bit_count_reg;
        length_shift_next   = length_shift_reg;
        checksum_shift_next = checksum_shift_reg;
        sec                 = psd_pkg::SEC_DEST;
        idx                 = bit_count_reg;
        last_bit            = 1'b0;

        case (phase_reg)
            psd_pkg::PH_HUNT: begin
                if (sync_count_reg < psd_pkg::SYNC_W'(psd_pkg::PREAMBLE_BITS)) begin
                    // even positions expect one, odd positions expect zero
                    if (bit_val == sync_count_reg[0]) begin
                        sync_count_next = '0;
                    end else begin
                        sync_count_next = sync_count_reg + psd_pkg::SYNC_W'(1);
                    end
                end else if (bit_val) begin
                    sync_count_next     = '0;
                    bit_count_next      = '0;
                    length_shift_next   = '0;
                    checksum_shift_next = '0;
                    phase_next          = psd_pkg::PH_HEADER;
                end else begin
                    // extra zero: step back to stay in the alternation
                    sync_count_next = sync_count_reg - psd_pkg::SYNC_W'(1);
                end
            end
            psd_pkg::PH_HEADER: begin
                if (bit_count_reg < psd_pkg::INDEX_W'(psd_pkg::ADDR_BITS)) begin
                    sec = psd_pkg::SEC_DEST;
                    idx = bit_count_reg;
                end else if (bit_count_reg < psd_pkg::INDEX_W'(2 * psd_pkg::ADDR_BITS)) begin
                    sec = psd_pkg::SEC_SOURCE;
                    idx = bit_count_reg - psd_pkg::INDEX_W'(psd_pkg::ADDR_BITS);
                end else begin
                    sec = psd_pkg::SEC_LENGTH;
                    idx = bit_count_reg - psd_pkg::INDEX_W'(2 * psd_pkg::ADDR_BITS);
                    length_shift_next = {length_shift_reg[psd_pkg::LEN_BITS-2:0], bit_val};
                end
                bit_count_next = count_inc[psd_pkg::INDEX_W-1:0];
                if (count_inc >= CNT_W'(psd_pkg::HEADER_BITS)) begin
                    bit_count_next = '0;
                    phase_next     = (payload_len == '0) ? psd_pkg::PH_CHECKSUM
                                                         : psd_pkg::PH_PAYLOAD;
                end
            end
            psd_pkg::PH_PAYLOAD: begin
                sec            = psd_pkg::SEC_PAYLOAD;
                bit_count_next = count_inc[psd_pkg::INDEX_W-1:0];
                if (count_inc >= CNT_W'(payload_len)) begin
                    bit_count_next = '0;
                    phase_next     = psd_pkg::PH_CHECKSUM;
                end
            end
            psd_pkg::PH_CHECKSUM: begin
                sec                 = psd_pkg::SEC_CHECKSUM;
                checksum_shift_next = {checksum_shift_reg[psd_pkg::CRC_BITS-2:0], bit_val};
                bit_count_next      = count_inc[psd_pkg::INDEX_W-1:0];
                if (count_inc >= CNT_W'(psd_pkg::CRC_BITS)) begin
                    last_bit        = 1'b1;
                    bit_count_next  = '0;
                    sync_count_next = '0;
                    phase_next      = psd_pkg::PH_HUNT;
                end
            end
            default: begin
                phase_next      = psd_pkg::PH_HUNT;
                sync_count_next = '0;
                bit_count_next  = '0;
            end
        endcase
    end

    // Hold or load the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample;
        end
    end

    // Update frame state once per processed sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= psd_pkg::PH_HUNT;
            sync_count_reg     <= '0;
            bit_count_reg      <= '0;
            length_shift_reg   <= '0;
            checksum_shift_reg <= '0;
        end else if (advance) begin
            phase_reg          <= phase_next;
            sync_count_reg     <= sync_count_next;
            bit_count_reg      <= bit_count_next;
            length_shift_reg   <= length_shift_next;
            checksum_shift_reg <= checksum_shift_next;
        end
    end

    // Result valid: set on load, drop after transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; frame fields only on the last bit
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_bit_reg       <= bit_val;
            out_section_reg   <= sec;
            out_index_reg     <= idx;
            out_last_reg      <= last_bit;
            out_length_reg    <= last_bit ? length_shift_next : '0;
            out_length_ok_reg <= last_bit &&
                                 (length_shift_next == psd_pkg::LEN_BITS'(payload_len));
            out_checksum_reg  <= last_bit ? checksum_shift_next : '0;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_bit_res        = out_bit_reg;
    assign m_section        = out_section_reg;
    assign m_bit_index      = out_index_reg;
    assign m_last           = out_last_reg;
    assign m_length_field   = out_length_reg;
    assign m_length_ok      = out_length_ok_reg;
    assign m_checksum_field = out_checksum_reg;

    // Assertions
    a_last_is_final_crc_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |->
            (m_section == psd_pkg::SEC_CHECKSUM &&
             m_bit_index == psd_pkg::INDEX_W'(psd_pkg::CRC_BITS - 1)))
        else $error("last flagged away from the final checksum bit");

    a_fields_zero_unless_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |->
            (m_length_field == '0 && m_checksum_field == '0 && !m_length_ok))
        else $error("frame fields set on a non-final bit");

    a_no_result_while_hunting: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && phase_reg == psd_pkg::PH_HUNT) |=> $stable(out_valid_reg) || !out_valid_reg)
        else $error("result produced while hunting");

    a_sync_only_in_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (sync_count_reg != '0) |-> (phase_reg == psd_pkg::PH_HUNT))
        else $error("sync count live outside the hunt");

    a_header_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == psd_pkg::PH_HEADER) |->
            (bit_count_reg < psd_pkg::INDEX_W'(psd_pkg::HEADER_BITS)))
        else $error("header bit count out of range");

endmodule
